// ===== hw/rtl/ssl_pkg.sv =====
package ssl_pkg;

    // Default number of fraction bits of the Q-format values.
    localparam int FRAC_BITS_DEF = 16;

    // log2(e) in Q.16.
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // Cap applied to the shifted spike term when it grows.
    localparam logic [62:0] B_CAP = 63'h4000_0000_0000_0000;

    // Register reset values.
    localparam logic [31:0] SPIKE_RESET = 32'd65536;
    localparam logic [31:0] SLAB_RESET  = 32'd65536;
    localparam logic [15:0] MIX_RESET   = 16'd32768;
    localparam logic [15:0] COUNT_RESET = 16'd1;
    localparam logic [31:0] CUTOFF_RESET = 32'd0;
    localparam logic [31:0] NOISE_RESET = 32'd65536;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SPIKE  = 3'd0,
        CFG_SLAB   = 3'd1,
        CFG_MIX    = 3'd2,
        CFG_COUNT  = 3'd3,
        CFG_CUTOFF = 3'd4,
        CFG_NOISE  = 3'd5
    } cfg_index_t;

    // Per-item information that rides along the pipeline.
    typedef struct packed {
        logic [31:0] zmag;
        logic        zneg;
        logic        active;
        logic        eq;
        logic        gt;
    } item_t;

    // Table of 2^(-i/16) in Q1.16, i from 0 to 16.
    function automatic logic [16:0] pow2_neg_tab(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/ssl_udiv_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit in QW bits, so the numerator bits above QW
// form the starting remainder and must be smaller than the divisor.
module ssl_udiv_pipe #(
    parameter int NW = 33,
    parameter int DW = 16,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic [SW-1:0] out_side
);

    logic          v_reg   [QW];
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] nq_reg  [QW];
    logic [DW-1:0] d_reg   [QW];
    logic [SW-1:0] sd_reg  [QW];

    genvar i;
    generate
        for (i = 0; i < QW; i++) begin : g_stage
            logic          v_src;
            logic [DW-1:0] rem_src;
            logic [QW-1:0] nq_src;
            logic [DW-1:0] d_src;
            logic [SW-1:0] sd_src;
            logic [DW:0]   sh;
            logic [DW:0]   sub;
            logic          ge;

            // Stage input: from the ports for the first stage.
            if (i == 0) begin : g_first
                assign v_src   = in_valid;
                assign rem_src = DW'(num[NW-1:QW]);
                assign nq_src  = num[QW-1:0];
                assign d_src   = den;
                assign sd_src  = in_side;
            end
            else begin : g_next
                assign v_src   = v_reg[i-1];
                assign rem_src = rem_reg[i-1];
                assign nq_src  = nq_reg[i-1];
                assign d_src   = d_reg[i-1];
                assign sd_src  = sd_reg[i-1];
            end

            // Shift in the next numerator bit and try the subtraction.
            assign sh  = {rem_src, nq_src[QW-1]};
            assign ge  = sh >= {1'b0, d_src};
            assign sub = sh - {1'b0, d_src};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[i] <= v_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= ge ? sub[DW-1:0] : sh[DW-1:0];
                    nq_reg[i]  <= {nq_src[QW-2:0], ge};
                    d_reg[i]   <= d_src;
                    sd_reg[i]  <= sd_src;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[QW-1];
    assign quot      = nq_reg[QW-1];
    assign out_side  = sd_reg[QW-1];

endmodule

// ===== hw/rtl/spike_slab_lasso_threshold_update.sv =====
// Spike-and-slab lasso coefficient update. Each input transaction carries a
// correlation score and the previous coefficient; each output transaction
// carries the new coefficient, one result for every input. The unit is fully
// pipelined and accepts one transaction per clock while the output is not stalled;
// it holds a 17-stage divider for the inclusion probability and a 32-stage
// divider by the sample count. The whole pipeline stalls while a result waits
// on the output. Configuration registers are read live by the pipeline, so
// they may be written only when no transaction is in flight.
module spike_slab_lasso_threshold_update #(
    parameter int FRAC_BITS = ssl_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Input stream. tdata: [31:0] correlation_score, [63:32] previous_coefficient.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // Output stream. tdata: [31:0] new_coefficient.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    localparam int ASH = 2 * FRAC_BITS - 16;

    // Configuration registers.
    logic [31:0] spike_reg, slab_reg, cutoff_reg, noise_reg;
    logic [15:0] mix_reg, count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spike_reg  <= ssl_pkg::SPIKE_RESET;
            slab_reg   <= ssl_pkg::SLAB_RESET;
            mix_reg    <= ssl_pkg::MIX_RESET;
            count_reg  <= ssl_pkg::COUNT_RESET;
            cutoff_reg <= ssl_pkg::CUTOFF_RESET;
            noise_reg  <= ssl_pkg::NOISE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssl_pkg::CFG_SPIKE:  spike_reg  <= cfg_data;
                ssl_pkg::CFG_SLAB:   slab_reg   <= cfg_data;
                ssl_pkg::CFG_MIX:    mix_reg    <= cfg_data[15:0];
                ssl_pkg::CFG_COUNT:  count_reg  <= cfg_data[15:0];
                ssl_pkg::CFG_CUTOFF: cutoff_reg <= cfg_data;
                ssl_pkg::CFG_NOISE:  noise_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Global pipeline advance.
    logic en;
    logic out_valid_reg;
    logic [31:0] out_data_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Stage 1: magnitudes and cutoff test.
    logic s1_v_reg;
    ssl_pkg::item_t s1_it_reg;
    logic [31:0] s1_xmag_reg;
    logic [31:0] z_in, x_in, zmag_c;

    assign z_in   = s_tdata[31:0];
    assign x_in   = s_tdata[63:32];
    assign zmag_c = z_in[31] ? (32'd0 - z_in) : z_in;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_it_reg.zmag   <= zmag_c;
            s1_it_reg.zneg   <= z_in[31];
            s1_it_reg.active <= zmag_c > cutoff_reg;
            s1_it_reg.eq     <= spike_reg == slab_reg;
            s1_it_reg.gt     <= spike_reg > slab_reg;
            s1_xmag_reg      <= x_in[31] ? (32'd0 - x_in) : x_in;
        end
    end

    // Stage 2: |x| times penalty difference.
    logic s2_v_reg;
    ssl_pkg::item_t s2_it_reg;
    logic [63:0] s2_p_reg;
    logic [31:0] dmag;

    assign dmag = s1_it_reg.gt ? (spike_reg - slab_reg) : (slab_reg - spike_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_it_reg <= s1_it_reg;
            s2_p_reg  <= 64'(s1_xmag_reg) * 64'(dmag);
        end
    end

    // Stage 3: exponent scaled by log2(e), with saturation test.
    logic s3_v_reg;
    ssl_pkg::item_t s3_it_reg;
    logic [56:0] s3_r_reg;
    logic        s3_sat_reg;
    logic [63:0] a_c;
    logic        sat_c;

    assign a_c   = s2_p_reg >> ASH;
    assign sat_c = |a_c[63:40];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_it_reg  <= s2_it_reg;
            s3_sat_reg <= sat_c;
            s3_r_reg   <= sat_c ? 57'd0 : 57'(a_c[39:0]) * 57'(ssl_pkg::LOG2E_Q16);
        end
    end

    // Stage 4: fractional power of two and the two weighted penalties.
    logic s4_v_reg;
    ssl_pkg::item_t s4_it_reg;
    logic [16:0] s4_m_reg;
    logic [5:0]  s4_k_reg;
    logic        s4_big_reg;
    logic [47:0] s4_a_reg, s4_c_reg;
    logic [15:0] f_c;
    logic [16:0] hi_c, lo_c, dhl_c;
    logic [28:0] interp_c;

    assign f_c      = s3_r_reg[31:16];
    assign hi_c     = ssl_pkg::pow2_neg_tab({1'b0, f_c[15:12]});
    assign lo_c     = ssl_pkg::pow2_neg_tab(5'({1'b0, f_c[15:12]}) + 5'd1);
    assign dhl_c    = hi_c - lo_c;
    assign interp_c = 29'(dhl_c) * 29'(f_c[11:0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_it_reg  <= s3_it_reg;
            s4_m_reg   <= hi_c - interp_c[28:12];
            s4_k_reg   <= s3_r_reg[37:32];
            s4_big_reg <= s3_sat_reg || (|s3_r_reg[56:38]);
            s4_a_reg   <= 48'(mix_reg) * 48'(slab_reg);
            s4_c_reg   <= 48'(17'd65536 - 17'(mix_reg)) * 48'(spike_reg);
        end
    end

    // Stage 5: spike term times the power of two.
    logic s5_v_reg;
    ssl_pkg::item_t s5_it_reg;
    logic [47:0] s5_b_reg, s5_a_reg;
    logic [5:0]  s5_k_reg;
    logic        s5_big_reg;
    logic [63:0] cm_c;

    assign cm_c = 64'(s4_c_reg) * 64'(s4_m_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_it_reg  <= s4_it_reg;
            s5_b_reg   <= cm_c[63:16];
            s5_a_reg   <= s4_a_reg;
            s5_k_reg   <= s4_k_reg;
            s5_big_reg <= s4_big_reg;
        end
    end

    // Stage 6: integer part of the exponent as a shift, with capping.
    logic s6_v_reg;
    ssl_pkg::item_t s6_it_reg;
    logic [62:0] s6_b_reg;
    logic [47:0] s6_a_reg;
    logic [62:0] b_c, cap_sh_c, b_up_c;

    assign cap_sh_c = ssl_pkg::B_CAP >> s5_k_reg;
    assign b_up_c   = 63'(s5_b_reg) << s5_k_reg;

    always_comb
    begin
        if (s5_it_reg.gt)
        begin
            b_c = s5_big_reg ? 63'd0 : 63'(s5_b_reg >> s5_k_reg);
        end
        else if (s5_b_reg == 48'd0)
        begin
            b_c = 63'd0;
        end
        else if (s5_big_reg || s5_k_reg >= 6'd62 || 63'(s5_b_reg) > cap_sh_c)
        begin
            b_c = ssl_pkg::B_CAP;
        end
        else
        begin
            b_c = b_up_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_it_reg <= s5_it_reg;
            s6_b_reg  <= b_c;
            s6_a_reg  <= s5_a_reg;
        end
    end

    // Stage 7: divisor and numerator for the inclusion probability.
    logic s7_v_reg;
    ssl_pkg::item_t s7_it_reg;
    logic [62:0] s7_d_reg;
    logic [47:0] s7_a_reg;
    logic        s7_za_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_it_reg <= s6_it_reg;
            s7_d_reg  <= 63'(s6_a_reg) + s6_b_reg;
            s7_a_reg  <= s6_a_reg;
            s7_za_reg <= s6_a_reg == 48'd0;
        end
    end

    // Probability divider.
    localparam int SIDE1 = $bits(ssl_pkg::item_t) + 1;
    logic             pd_v;
    logic [16:0]      pd_q;
    logic [SIDE1-1:0] pd_side;
    ssl_pkg::item_t   pd_it;
    logic             pd_za;

    ssl_udiv_pipe #(
        .NW(64),
        .DW(63),
        .QW(17),
        .SW(SIDE1)
    ) u_pdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s7_v_reg),
        .num      ({s7_a_reg, 16'd0}),
        .den      (s7_d_reg),
        .in_side  ({s7_it_reg, s7_za_reg}),
        .out_valid(pd_v),
        .quot     (pd_q),
        .out_side (pd_side)
    );

    assign pd_it = pd_side[SIDE1-1:1];
    assign pd_za = pd_side[0];

    // Stage 8: the two probability-weighted penalties.
    logic s8_v_reg;
    ssl_pkg::item_t s8_it_reg;
    logic [48:0] s8_m1_reg, s8_m0_reg;
    logic [16:0] p_c;

    assign p_c = pd_za ? 17'd0 : pd_q;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_it_reg <= pd_it;
            s8_m1_reg <= 49'(p_c) * 49'(slab_reg);
            s8_m0_reg <= 49'(17'd65536 - p_c) * 49'(spike_reg);
        end
    end

    // Stage 9: mixed penalty.
    logic s9_v_reg;
    ssl_pkg::item_t s9_it_reg;
    logic [31:0] s9_lam_reg;
    logic [49:0] lsum_c;

    assign lsum_c = 50'(s8_m1_reg) + 50'(s8_m0_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_it_reg  <= s8_it_reg;
            s9_lam_reg <= s8_it_reg.eq ? slab_reg : lsum_c[47:16];
        end
    end

    // Stage 10: noise variance times penalty.
    logic s10_v_reg;
    ssl_pkg::item_t s10_it_reg;
    logic [63:0] s10_prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_it_reg   <= s9_it_reg;
            s10_prod_reg <= 64'(noise_reg) * 64'(s9_lam_reg);
        end
    end

    // Stage 11: soft threshold.
    logic s11_v_reg;
    logic s11_zneg_reg;
    logic [31:0] s11_diff_reg;
    logic [15:0] s11_n_reg;
    logic [63:0] pen_c;
    logic        keep_c;

    assign pen_c  = s10_prod_reg >> FRAC_BITS;
    assign keep_c = s10_it_reg.active && (pen_c < 64'(s10_it_reg.zmag));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_zneg_reg <= s10_it_reg.zneg;
            s11_diff_reg <= keep_c ? (s10_it_reg.zmag - pen_c[31:0]) : 32'd0;
            s11_n_reg    <= (count_reg == 16'd0) ? 16'd1 : count_reg;
        end
    end

    // Division by the sample count.
    logic        qd_v;
    logic [31:0] qd_q;
    logic        qd_zneg;

    ssl_udiv_pipe #(
        .NW(33),
        .DW(16),
        .QW(32),
        .SW(1)
    ) u_ndiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s11_v_reg),
        .num      ({1'b0, s11_diff_reg}),
        .den      (s11_n_reg),
        .in_side  (s11_zneg_reg),
        .out_valid(qd_v),
        .quot     (qd_q),
        .out_side (qd_zneg)
    );

    // Sign and saturation into the output register.
    logic [31:0] res_c;

    always_comb
    begin
        if (qd_zneg)
        begin
            res_c = qd_q[31] ? 32'h8000_0000 : (32'd0 - qd_q);
        end
        else
        begin
            res_c = qd_q[31] ? 32'h7FFF_FFFF : qd_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= res_c;
        end
    end

    // Valid bits of the stages outside the dividers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            s6_v_reg      <= 1'b0;
            s7_v_reg      <= 1'b0;
            s8_v_reg      <= 1'b0;
            s9_v_reg      <= 1'b0;
            s10_v_reg     <= 1'b0;
            s11_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg      <= s_tvalid;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= s3_v_reg;
            s5_v_reg      <= s4_v_reg;
            s6_v_reg      <= s5_v_reg;
            s7_v_reg      <= s6_v_reg;
            s8_v_reg      <= pd_v;
            s9_v_reg      <= s8_v_reg;
            s10_v_reg     <= s9_v_reg;
            s11_v_reg     <= s10_v_reg;
            out_valid_reg <= qd_v;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hw/rtl/ssl_checker.sv =====
// Port-level checks for the threshold update block.
module ssl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transaction dropped while stalled");

    // Input is refused exactly while a result is stalled.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // A held result keeps its value.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output data changed while stalled");

endmodule

bind spike_slab_lasso_threshold_update ssl_checker u_ssl_checker (.*);
